FILE: hdl/stdp_pkg.sv
// Shared types, constants and helpers for the structure tensor disparity block.
`timescale 1ns / 1ps
package stdp_pkg;

  localparam int IN_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam int DISP_W     = 32;
  localparam int TRUST_W    = 17;
  localparam int TRUST_FRAC = 16;
  localparam int CH_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CH_W-1:0] CH_BLUE  = 2'd0;
  localparam logic [CH_W-1:0] CH_GREEN = 2'd1;
  localparam logic [CH_W-1:0] CH_RED   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COLOUR_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_FLOOR = 1'd1;

  localparam logic                  COLOUR_MODE_RESET  = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ENERGY_FLOOR_RESET = 32'd1;

  localparam logic [TRUST_W-1:0] TRUST_ONE = 17'h1_0000;
  localparam logic [DISP_W-1:0]  DISP_MAX  = 32'h7FFF_FFFF;
  localparam logic [DISP_W-1:0]  DISP_MIN  = 32'h8000_0000;

  // Result of one colour channel, handed to the channel select
  typedef struct packed {
    logic [DISP_W-1:0]  disp;
    logic [TRUST_W-1:0] trust;
    logic               no_slope;
  } ch_res_t;

  // -2500.0 in the output format, clamped to the most negative code
  function automatic logic [DISP_W-1:0] disp_sentinel(input int frac);
    logic [63:0] mag;
    mag = 64'd2500 << frac;
    if (mag > 64'h8000_0000) return DISP_MIN;
    return DISP_W'(64'd0 - mag);
  endfunction

endpackage

FILE: hdl/stdp_delay.sv
// Fixed-length shift line that moves a word one tap per enabled cycle.
`timescale 1ns / 1ps
module stdp_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign q = taps[DEPTH-1];

endmodule

FILE: hdl/stdp_sqrt_cell.sv
// One digit cell of the pipelined floor square root.
`timescale 1ns / 1ps
module stdp_sqrt_cell #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [W+2:0]         rem_i,
  input  logic [W:0]           root_i,
  input  logic [2*(W+1)-1:0]   rad_i,
  output logic [W+2:0]         rem_o,
  output logic [W:0]           root_o,
  output logic [2*(W+1)-1:0]   rad_o
);

  localparam int RMW = W + 3;
  localparam int RTW = W + 1;
  localparam int RDW = 2 * (W + 1);

  logic [RMW-1:0] shifted;
  logic [RMW-1:0] trial;
  logic           ge;

  // bring down the next two radicand bits, try root*4+1
  assign shifted = {rem_i[RMW-3:0], rad_i[RDW-1 -: 2]};
  assign trial   = {root_i, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? shifted - trial : shifted;
      root_o <= {root_i[RTW-2:0], ge};
      rad_o  <= {rad_i[RDW-3:0], 2'b00};
    end
  end

endmodule

FILE: hdl/stdp_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
`timescale 1ns / 1ps
module stdp_div_cell #(
  parameter int DW = 33,
  parameter int QW = 32,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] d_i,
  input  logic [QW-1:0] q_i,
  input  logic [BW-1:0] bits_i,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] d_o,
  output logic [QW-1:0] q_o,
  output logic [BW-1:0] bits_o
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // remainder stays below the divisor, so trial fits one extra bit
  assign trial = {rem_i, bits_i[BW-1]};
  assign diff  = trial - {1'b0, d_i};
  assign ge    = trial >= {1'b0, d_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[DW-1:0] : trial[DW-1:0];
      d_o    <= d_i;
      q_o    <= {q_i[QW-2:0], ge};
      bits_o <= bits_i << 1;
    end
  end

endmodule

FILE: hdl/stdp_channel.sv
// Per-channel datapath: tensor terms, square root, disparity and trust dividers.
`timescale 1ns / 1ps
module stdp_channel
  import stdp_pkg::*;
#(
  parameter int W = IN_WIDTH_DEF,
  parameter int F = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [CFG_DATA_W-1:0] energy_floor,
  input  logic [W-1:0]          xx,
  input  logic [W-1:0]          yy,
  input  logic [W-1:0]          xy,
  output ch_res_t               res
);

  localparam int SQ  = W + 1;               // square root digits
  localparam int QB  = DISP_W;              // disparity quotient bits
  localparam int TQ  = TRUST_FRAC;          // trust quotient bits
  localparam int EW  = 2 * W + 1;           // energy width
  localparam int TW  = 2 * W + 2;           // trace squared width
  localparam int RMW = W + 3;
  localparam int RDW = 2 * (W + 1);
  localparam int DDW = W + 1;               // disparity divisor width
  localparam int NW  = W + 2 + F;           // scaled numerator width
  localparam int XW  = NW + QB;
  localparam int CW  = (NW > W + QB + 1) ? NW : W + QB + 1;
  localparam int TDLY = 1 + SQ + QB - TQ;
  localparam logic [DISP_W-1:0] SENT = disp_sentinel(F);

  // stage 1: magnitudes, signs, trace
  logic         r1_dneg, r1_xyneg;
  logic [W-1:0] r1_dmag, r1_xymag;
  logic [W:0]   r1_trace;

  always_ff @(posedge clk) begin
    if (en) begin
      r1_dneg  <= yy < xx;
      r1_dmag  <= (yy < xx) ? xx - yy : yy - xx;
      r1_xyneg <= xy[W-1];
      r1_xymag <= xy[W-1] ? ~xy + W'(1) : xy;
      r1_trace <= {1'b0, xx} + {1'b0, yy};
    end
  end

  // stage 2: squares
  logic [2*W-1:0] r2_dsq, r2_xsq;
  logic [TW-1:0]  r2_tsq;
  logic           r2_dneg, r2_xyneg;
  logic [W-1:0]   r2_dmag, r2_xymag;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_dsq   <= r1_dmag * r1_dmag;
      r2_xsq   <= r1_xymag * r1_xymag;
      r2_tsq   <= r1_trace * r1_trace;
      r2_dneg  <= r1_dneg;
      r2_dmag  <= r1_dmag;
      r2_xyneg <= r1_xyneg;
      r2_xymag <= r1_xymag;
    end
  end

  // stage 3: energy, floor and saturation flags
  logic [EW-1:0] energy_sum;
  logic [EW-1:0] r3_energy;
  logic [TW-1:0] r3_trace2;
  logic          r3_low, r3_sat;
  logic          r3_dneg, r3_xyneg;
  logic [W-1:0]  r3_dmag, r3_xymag;

  assign energy_sum = {1'b0, r2_dsq} + {r2_xsq[2*W-2:0], 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      r3_energy <= energy_sum;
      r3_trace2 <= r2_tsq;
      r3_low    <= (r2_tsq == '0) || (r2_tsq < TW'(energy_floor));
      r3_sat    <= {1'b0, energy_sum} >= r2_tsq;
      r3_dneg   <= r2_dneg;
      r3_dmag   <= r2_dmag;
      r3_xyneg  <= r2_xyneg;
      r3_xymag  <= r2_xymag;
    end
  end

  // square root chain
  logic [RMW-1:0] sq_rem  [SQ+1];
  logic [W:0]     sq_root [SQ+1];
  logic [RDW-1:0] sq_rad  [SQ+1];

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = {1'b0, r3_energy};

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    stdp_sqrt_cell #(.W(W)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (sq_rem[g]),
      .root_i (sq_root[g]),
      .rad_i  (sq_rad[g]),
      .rem_o  (sq_rem[g+1]),
      .root_o (sq_root[g+1]),
      .rad_o  (sq_rad[g+1])
    );
  end

  logic         sq_dneg, sq_xyneg;
  logic [W-1:0] sq_dmag, sq_xymag;

  stdp_delay #(.WIDTH(2 * W + 2), .DEPTH(SQ)) u_sq_side (
    .clk (clk),
    .en  (en),
    .d   ({r3_dmag, r3_dneg, r3_xymag, r3_xyneg}),
    .q   ({sq_dmag, sq_dneg, sq_xymag, sq_xyneg})
  );

  // numerator: sqrt(energy) + diff, never negative
  logic [W+1:0] rn_num;
  logic [W-1:0] rn_xymag;
  logic         rn_xyneg;

  always_ff @(posedge clk) begin
    if (en) begin
      rn_num   <= sq_dneg ? {1'b0, sq_root[SQ]} - {2'b00, sq_dmag}
                          : {1'b0, sq_root[SQ]} + {2'b00, sq_dmag};
      rn_xymag <= sq_xymag;
      rn_xyneg <= sq_xyneg;
    end
  end

  // divider setup: overflow check and initial partial remainder
  logic [NW-1:0]  n_div;
  logic [XW-1:0]  n_ext;
  logic [DDW-1:0] ro_rem, ro_d;
  logic [QB-1:0]  ro_bits;
  logic           ro_ovf, ro_xyneg, ro_noslope;

  assign n_div = {rn_num, {F{1'b0}}};
  assign n_ext = {{QB{1'b0}}, n_div};

  always_ff @(posedge clk) begin
    if (en) begin
      ro_rem     <= DDW'(n_ext[XW-1:QB]);
      ro_bits    <= n_ext[QB-1:0];
      ro_d       <= {rn_xymag, 1'b0};
      ro_ovf     <= CW'(n_div) >= CW'({rn_xymag, {(QB+1){1'b0}}});
      ro_xyneg   <= rn_xyneg;
      ro_noslope <= rn_xymag == '0;
    end
  end

  // disparity divider chain
  logic [DDW-1:0] dv_rem  [QB+1];
  logic [DDW-1:0] dv_d    [QB+1];
  logic [QB-1:0]  dv_q    [QB+1];
  logic [QB-1:0]  dv_bits [QB+1];

  assign dv_rem[0]  = ro_rem;
  assign dv_d[0]    = ro_d;
  assign dv_q[0]    = '0;
  assign dv_bits[0] = ro_bits;

  for (genvar g = 0; g < QB; g++) begin : g_ddiv
    stdp_div_cell #(.DW(DDW), .QW(QB), .BW(QB)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (dv_rem[g]),
      .d_i    (dv_d[g]),
      .q_i    (dv_q[g]),
      .bits_i (dv_bits[g]),
      .rem_o  (dv_rem[g+1]),
      .d_o    (dv_d[g+1]),
      .q_o    (dv_q[g+1]),
      .bits_o (dv_bits[g+1])
    );
  end

  logic dv_ovf, dv_xyneg, dv_noslope;

  stdp_delay #(.WIDTH(3), .DEPTH(QB)) u_dv_side (
    .clk (clk),
    .en  (en),
    .d   ({ro_ovf, ro_xyneg, ro_noslope}),
    .q   ({dv_ovf, dv_xyneg, dv_noslope})
  );

  // trust divider chain, runs beside the square root
  logic [TW-1:0] tv_rem  [TQ+1];
  logic [TW-1:0] tv_d    [TQ+1];
  logic [TQ-1:0] tv_q    [TQ+1];
  logic [0:0]    tv_bits [TQ+1];

  assign tv_rem[0]  = TW'(r3_energy);
  assign tv_d[0]    = r3_trace2;
  assign tv_q[0]    = '0;
  assign tv_bits[0] = 1'b0;

  for (genvar g = 0; g < TQ; g++) begin : g_tdiv
    stdp_div_cell #(.DW(TW), .QW(TQ), .BW(1)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (tv_rem[g]),
      .d_i    (tv_d[g]),
      .q_i    (tv_q[g]),
      .bits_i (tv_bits[g]),
      .rem_o  (tv_rem[g+1]),
      .d_o    (tv_d[g+1]),
      .q_o    (tv_q[g+1]),
      .bits_o (tv_bits[g+1])
    );
  end

  logic tv_low, tv_sat;

  stdp_delay #(.WIDTH(2), .DEPTH(TQ)) u_tv_side (
    .clk (clk),
    .en  (en),
    .d   ({r3_low, r3_sat}),
    .q   ({tv_low, tv_sat})
  );

  logic [TRUST_W-1:0] rt_trust, trust_al;

  always_ff @(posedge clk) begin
    if (en) begin
      if (tv_low)      rt_trust <= '0;
      else if (tv_sat) rt_trust <= TRUST_ONE;
      else             rt_trust <= {1'b0, tv_q[TQ]};
    end
  end

  // hold trust until the disparity catches up
  stdp_delay #(.WIDTH(TRUST_W), .DEPTH(TDLY)) u_tv_align (
    .clk (clk),
    .en  (en),
    .d   (rt_trust),
    .q   (trust_al)
  );

  // final: sign, saturation, sentinel
  logic [QB-1:0] q_fin;
  assign q_fin = dv_q[QB];

  always_ff @(posedge clk) begin
    if (en) begin
      res.trust    <= trust_al;
      res.no_slope <= dv_noslope;
      if (dv_noslope)
        res.disp <= SENT;
      else if (!dv_xyneg)
        res.disp <= (dv_ovf || q_fin[QB-1]) ? DISP_MAX : q_fin;
      else
        res.disp <= (dv_ovf || q_fin > DISP_MIN) ? DISP_MIN : DISP_W'(~q_fin + 1'b1);
    end
  end

endmodule

FILE: hdl/structure_tensor_disparity_pixel.sv
// Top level: three channel pipelines, channel select, output register and skid.
//
//  port group        | dir | handshake           | payload
//  ------------------+-----+---------------------+----------------------------------
//  input pixel       | in  | in_valid / in_stall | xx_*, yy_*, xy_* for blue,green,red
//  result            | out | out_valid/out_stall | disparity, trust, chosen_channel,
//                    |     |                     | no_slope
//  configuration     | in  | cfg_we              | cfg_index, cfg_data
//
// One item enters every cycle while in_stall is low; each result passes through the
// square root cells (one per root bit) and the 32 disparity divider cells that each
// channel runs in a single shifting chain.
// Reset clears the valid line, the output and skid valid flags and the
// configuration (colour mode on, energy floor one).
// A stall on the result side first fills the skid stage; only then does the
// whole chain freeze and in_stall rise, so one more result is parked while another
// waits in the output register.
`timescale 1ns / 1ps
module structure_tensor_disparity_pixel
  import stdp_pkg::*;
#(
  parameter int IN_WIDTH  = IN_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [IN_WIDTH-1:0]        xx_blue,
  input  logic [IN_WIDTH-1:0]        yy_blue,
  input  logic signed [IN_WIDTH-1:0] xy_blue,
  input  logic [IN_WIDTH-1:0]        xx_green,
  input  logic [IN_WIDTH-1:0]        yy_green,
  input  logic signed [IN_WIDTH-1:0] xy_green,
  input  logic [IN_WIDTH-1:0]        xx_red,
  input  logic [IN_WIDTH-1:0]        yy_red,
  input  logic signed [IN_WIDTH-1:0] xy_red,

  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [DISP_W-1:0]   disparity,
  output logic [TRUST_W-1:0]         trust,
  output logic [CH_W-1:0]            chosen_channel,
  output logic                       no_slope,

  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // matches the register stages inside one channel
  localparam int CH_LAT = 7 + IN_WIDTH + DISP_W;

  // configuration registers
  logic                  colour_mode;
  logic [CFG_DATA_W-1:0] energy_floor;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_mode  <= COLOUR_MODE_RESET;
      energy_floor <= ENERGY_FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOUR_MODE:  colour_mode  <= cfg_data[0];
        REG_ENERGY_FLOOR: energy_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // the chain advances whenever the skid stage is free
  logic skid_valid;
  logic en;
  logic in_take;

  assign en       = !skid_valid;
  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;

  // valid bit for every chain stage
  logic [CH_LAT-1:0] vline;

  always_ff @(posedge clk) begin
    if (rst) vline <= '0;
    else if (en) vline <= {vline[CH_LAT-2:0], in_take};
  end

  // three channel pipelines in lockstep
  ch_res_t res_b, res_g, res_r;

  stdp_channel #(.W(IN_WIDTH), .F(FRAC_BITS)) u_blue (
    .clk (clk), .en (en), .energy_floor (energy_floor),
    .xx (xx_blue), .yy (yy_blue), .xy (xy_blue), .res (res_b)
  );

  stdp_channel #(.W(IN_WIDTH), .F(FRAC_BITS)) u_green (
    .clk (clk), .en (en), .energy_floor (energy_floor),
    .xx (xx_green), .yy (yy_green), .xy (xy_green), .res (res_g)
  );

  stdp_channel #(.W(IN_WIDTH), .F(FRAC_BITS)) u_red (
    .clk (clk), .en (en), .energy_floor (energy_floor),
    .xx (xx_red), .yy (yy_red), .xy (xy_red), .res (res_r)
  );

  // pick the most trusted channel in colour mode, blue otherwise; ties fall toward blue, then green
  logic [CH_W-1:0] sel;
  ch_res_t         sel_res;

  always_comb begin
    sel = CH_BLUE;
    if (colour_mode) begin
      if (res_r.trust > res_g.trust) sel = (res_r.trust > res_b.trust) ? CH_RED : CH_BLUE;
      else                           sel = (res_g.trust > res_b.trust) ? CH_GREEN : CH_BLUE;
    end
  end

  always_comb begin
    unique case (sel)
      CH_GREEN: sel_res = res_g;
      CH_RED:   sel_res = res_r;
      default:  sel_res = res_b;
    endcase
  end

  // output register plus one skid entry
  logic push, pop;
  ch_res_t         skid_res;
  logic [CH_W-1:0] skid_ch;

  assign push = en && vline[CH_LAT-1];
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) skid_valid <= 1'b1;
      else           out_valid  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      disparity      <= skid_res.disp;
      trust          <= skid_res.trust;
      no_slope       <= skid_res.no_slope;
      chosen_channel <= skid_ch;
    end else if (push && (pop || !out_valid)) begin
      disparity      <= sel_res.disp;
      trust          <= sel_res.trust;
      no_slope       <= sel_res.no_slope;
      chosen_channel <= sel;
    end
    // park the new item when the output register is still held
    if (push && out_valid && !pop) begin
      skid_res <= sel_res;
      skid_ch  <= sel;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds an item while the output register is empty");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_slope |-> disparity == disp_sentinel(FRAC_BITS))
    else $error("no_slope set without the sentinel disparity");

  a_trust_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> trust <= TRUST_ONE)
    else $error("trust above one");

  a_grey_blue: assert property (@(posedge clk) disable iff (rst)
    out_valid && !colour_mode |-> chosen_channel == CH_BLUE)
    else $error("grey mode chose a channel other than blue");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the structure tensor disparity pixel block.
`timescale 1ns / 1ps
module testbench;
  import stdp_pkg::*;

  localparam int W = IN_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int LATENCY = W + 40;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [W-1:0] xx;
    logic [W-1:0] yy;
    logic [W-1:0] xy;
  } tensor_t;

  typedef struct packed {
    tensor_t red;
    tensor_t green;
    tensor_t blue;
  } pixel_t;

  typedef struct packed {
    logic [DISP_W-1:0] disp;
    logic [TRUST_W-1:0] trust;
    logic [CH_W-1:0] chan;
    logic no_slope;
  } slope_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [W-1:0] xx_blue = '0, yy_blue = '0, xy_blue = '0;
  logic [W-1:0] xx_green = '0, yy_green = '0, xy_green = '0;
  logic [W-1:0] xx_red = '0, yy_red = '0, xy_red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DISP_W-1:0] disparity;
  logic [TRUST_W-1:0] trust;
  logic [CH_W-1:0] chosen_channel;
  logic no_slope;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COLOUR_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the configuration registers
  logic pred_colour_mode = COLOUR_MODE_RESET;
  logic [CFG_DATA_W-1:0] pred_energy_floor = ENERGY_FLOOR_RESET;

  pixel_t pending_pixels[$];
  slope_t expected_slopes[$];
  int errors = 0;
  int pixels_sent = 0;
  int slopes_seen = 0;
  int cycle_count = 0;
  bit driving_done = 1'b0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;

  structure_tensor_disparity_pixel DUT (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // Floored integer square root of a value below 2^128
  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  // One channel: disparity from orientation, trust from coherence
  function automatic slope_t channel_slope(input tensor_t t);
    slope_t s;
    logic xy_neg, d_neg;
    logic [W-1:0] xy_mag, d_mag;
    logic [127:0] energy, trace2, q;
    logic [63:0] root, num, tr;
    xy_neg = t.xy[W-1];
    xy_mag = xy_neg ? (~t.xy + 1'b1) : t.xy;
    d_neg = t.yy < t.xx;
    d_mag = d_neg ? t.xx - t.yy : t.yy - t.xx;
    energy = 128'(d_mag) * 128'(d_mag) + ((128'(xy_mag) * 128'(xy_mag)) << 2);
    tr = 64'(t.xx) + 64'(t.yy);
    trace2 = 128'(tr) * 128'(tr);
    root = isqrt(energy);
    num = d_neg ? root - 64'(d_mag) : root + 64'(d_mag);
    s = '0;
    if (xy_mag == 0) begin
      // Flat orientation: divide by zero gives the sentinel
      s.disp = disp_sentinel(FB);
      s.no_slope = 1'b1;
    end else begin
      q = (128'(num) << FB) / (128'(xy_mag) << 1);
      if (!xy_neg) s.disp = (q > 128'h7FFF_FFFF) ? DISP_MAX : q[31:0];
      else s.disp = (q > 128'h8000_0000) ? DISP_MIN : (32'd0 - q[31:0]);
    end
    if (trace2 == 0 || trace2 < 128'(pred_energy_floor)) s.trust = '0;
    else if (energy >= trace2) s.trust = TRUST_ONE;
    else s.trust = TRUST_W'((energy << TRUST_FRAC) / trace2);
    return s;
  endfunction

  function automatic slope_t pixel_slope(input pixel_t p);
    slope_t b, g, r, pick;
    b = channel_slope(p.blue);
    g = channel_slope(p.green);
    r = channel_slope(p.red);
    pick = b;
    pick.chan = CH_BLUE;
    if (pred_colour_mode) begin
      // Ties lean toward blue, then green
      if (r.trust > g.trust) begin
        if (r.trust > b.trust) begin
          pick = r;
          pick.chan = CH_RED;
        end
      end else if (g.trust > b.trust) begin
        pick = g;
        pick.chan = CH_GREEN;
      end
    end
    return pick;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch at slope %0d: %s got %h want %h", slopes_seen, what, got, want);
    errors++;
  endtask

  function automatic logic [W-1:0] rand_field();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(W-1){1'b0}}};
      3: return {1'b0, {(W-1){1'b1}}};
      4: return W'($urandom_range(0, 255));
      default: return W'($urandom);
    endcase
  endfunction

  function automatic tensor_t rand_tensor();
    tensor_t t;
    t.xx = rand_field();
    t.yy = rand_field();
    t.xy = rand_field();
    // Make tied or nearly isotropic tensors common
    if ($urandom_range(0, 5) == 0) t.yy = t.xx;
    if ($urandom_range(0, 7) == 0) t.xy = '0;
    return t;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.blue = rand_tensor();
    p.green = rand_tensor();
    p.red = rand_tensor();
    // Identical channels exercise the tie rules
    case ($urandom_range(0, 9))
      0: p.green = p.blue;
      1: p.red = p.green;
      2: p.red = p.blue;
      default: ;
    endcase
    return p;
  endfunction

  function automatic tensor_t tensor_of(input logic [W-1:0] xx, input logic [W-1:0] yy,
                                        input logic [W-1:0] xy);
    tensor_t t;
    t.xx = xx;
    t.yy = yy;
    t.xy = xy;
    return t;
  endfunction

  // Capture the input handshake at the rising edge where it takes effect
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
  end

  // Driver: offer queued pixels with random gaps, hold the payload under stall
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        expected_slopes.push_back(pixel_slope(pending_pixels.pop_front()));
        pixels_sent++;
      end
      if (!in_valid || in_taken) begin
        if (pending_pixels.size() > 0 && ($urandom_range(0, 3) != 0 || hold_off)) begin
          in_valid <= 1'b1;
          {xx_red, yy_red, xy_red} <= pending_pixels[0].red;
          {xx_green, yy_green, xy_green} <= pending_pixels[0].green;
          {xx_blue, yy_blue, xy_blue} <= pending_pixels[0].blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: short gaps mostly, a few long ones, plus one long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 19))
        0: stall_left <= $urandom_range(20, 80);
        1, 2, 3: stall_left <= $urandom_range(0, 3);
        default: ;
      endcase
      out_stall <= 1'b0;
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_slopes.size() == 0) begin
        report("unexpected item", 64'(disparity), 64'd0);
      end else begin
        slope_t e;
        e = expected_slopes.pop_front();
        if (disparity !== e.disp) report("disparity", 64'(disparity), 64'(e.disp));
        if (trust !== e.trust) report("trust", 64'(trust), 64'(e.trust));
        if (chosen_channel !== e.chan) report("chosen_channel", 64'(chosen_channel), 64'(e.chan));
        if (no_slope !== e.no_slope) report("no_slope", 64'(no_slope), 64'(e.no_slope));
      end
      slopes_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_COLOUR_MODE) pred_colour_mode = val[0];
    else pred_energy_floor = val;
  endtask

  // Wait until every pixel is in and every result out, then let the pipe drain
  task automatic drain();
    while (pending_pixels.size() > 0 || in_valid || expected_slopes.size() > 0)
      @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) pending_pixels.push_back(rand_pixel());
  endtask

  initial begin
    pixel_t p;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels at reset settings
    p.blue = tensor_of('0, '0, '0);
    p.green = tensor_of('1, '1, '1);
    p.red = tensor_of('1, '0, {1'b1, {(W-1){1'b0}}});
    pending_pixels.push_back(p);
    p.blue = tensor_of('1, '0, {1'b0, {(W-1){1'b1}}});
    p.green = tensor_of(32'd1, 32'd0, 32'd1);
    p.red = tensor_of('0, '1, 32'hFFFF_FFFF);
    pending_pixels.push_back(p);
    // Equal tensors in all channels: blue wins the tie
    p.blue = tensor_of(32'h1000_0000, 32'h0800_0000, 32'h0400_0000);
    p.green = p.blue;
    p.red = p.blue;
    pending_pixels.push_back(p);
    // Red and green tie above blue: green wins
    p.blue = tensor_of(32'h1000_0000, 32'h1000_0000, 32'd0);
    p.green = tensor_of(32'h1000_0000, 32'd0, 32'h0000_0010);
    p.red = p.green;
    pending_pixels.push_back(p);
    // Tiny slopes that saturate the disparity both ways
    p.blue = tensor_of(32'd0, 32'hFFFF_0000, 32'd1);
    p.green = tensor_of(32'd0, 32'hFFFF_0000, 32'hFFFF_FFFF);
    p.red = tensor_of(32'd5, 32'd3, 32'd2);
    pending_pixels.push_back(p);
    p.blue = tensor_of(32'd0, 32'd0, 32'h7FFF_FFFF);
    p.green = tensor_of(32'd3, 32'd5, 32'h8000_0001);
    p.red = tensor_of(32'h8000_0000, 32'h8000_0000, 32'd0);
    pending_pixels.push_back(p);
    random_phase(14);
    drain();

    // Grey mode with the floor at its top
    write_reg(REG_COLOUR_MODE, 32'd0);
    write_reg(REG_ENERGY_FLOOR, 32'hFFFF_FFFF);
    random_phase(120);
    drain();

    // Colour mode, floor at zero; hold the receiver off while items keep coming
    write_reg(REG_COLOUR_MODE, 32'd1);
    write_reg(REG_ENERGY_FLOOR, 32'd0);
    random_phase(140);
    hold_off = 1'b1;
    repeat (LATENCY * 3) @(negedge clk);
    hold_off = 1'b0;
    drain();

    // Mid-range floor, then reset values again
    write_reg(REG_ENERGY_FLOOR, 32'h0001_0000 | 32'($urandom_range(0, 65535)));
    random_phase(120);
    drain();
    write_reg(REG_COLOUR_MODE, 32'd1);
    write_reg(REG_ENERGY_FLOOR, 32'd1);
    random_phase(100);
    drain();

    $display("sent %0d pixels, checked %0d results over grey and colour modes", pixels_sent,
             slopes_seen);
    $display("energy floors covered zero, one, mid-range and all ones; %0d mismatches", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
